@@ rtl/core/integer_to_roman_numeral_assert.svh @@
// Assertion macros shared by the converter RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2R_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_to_roman_numeral check failed");

// Next-cycle implication, disabled during reset.
`define I2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_to_roman_numeral check failed");

`endif

@@ rtl/core/i2r_pkg.sv @@
package i2r_pkg;

  // ASCII codes of the numeral letters.
  localparam logic [7:0] ASCII_I = 8'h49;
  localparam logic [7:0] ASCII_V = 8'h56;
  localparam logic [7:0] ASCII_X = 8'h58;
  localparam logic [7:0] ASCII_L = 8'h4C;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_D = 8'h44;
  localparam logic [7:0] ASCII_M = 8'h4D;
  localparam logic [7:0] ASCII_NONE = 8'h00;

  // Decimal places, least significant first.
  localparam logic [1:0] PLACE_ONES = 2'd0;
  localparam logic [1:0] PLACE_TENS = 2'd1;
  localparam logic [1:0] PLACE_HUND = 2'd2;
  localparam logic [1:0] PLACE_THOU = 2'd3;

  // Letter role within a place: low, middle or high letter.
  localparam logic [1:0] SEL_LO = 2'd0;
  localparam logic [1:0] SEL_MI = 2'd1;
  localparam logic [1:0] SEL_HI = 2'd2;

  // Weight that the shared subtractor removes at each place.
  function automatic logic [9:0] place_weight(input logic [1:0] place);
    logic [9:0] w;
    case (place)
      PLACE_THOU: w = 10'd1000;
      PLACE_HUND: w = 10'd100;
      default:    w = 10'd10;
    endcase
    return w;
  endfunction

  // Number of letters a decimal digit yields (0 to 4).
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd2, 4'd3: n = d[2:0];
      4'd4, 4'd9:       n = 3'd2;
      4'd5:             n = 3'd1;
      4'd6:             n = 3'd2;
      4'd7:             n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // Which letter of the place stands at position pos of digit d.
  function automatic logic [1:0] digit_sel(input logic [3:0] d, input logic [1:0] pos);
    logic [1:0] s;
    case (d)
      4'd4:                   s = (pos == 2'd0) ? SEL_LO : SEL_MI;
      4'd5, 4'd6, 4'd7, 4'd8: s = (pos == 2'd0) ? SEL_MI : SEL_LO;
      4'd9:                   s = (pos == 2'd0) ? SEL_LO : SEL_HI;
      default:                s = SEL_LO;
    endcase
    return s;
  endfunction

  // Letter triple of each place: I/V/X, X/L/C, C/D/M, and M for thousands.
  function automatic logic [7:0] roman_letter(input logic [1:0] place,
                                              input logic [1:0] sel);
    logic [7:0] ch;
    case (place)
      PLACE_ONES: ch = (sel == SEL_LO) ? ASCII_I : (sel == SEL_MI) ? ASCII_V : ASCII_X;
      PLACE_TENS: ch = (sel == SEL_LO) ? ASCII_X : (sel == SEL_MI) ? ASCII_L : ASCII_C;
      PLACE_HUND: ch = (sel == SEL_LO) ? ASCII_C : (sel == SEL_MI) ? ASCII_D : ASCII_M;
      default:    ch = ASCII_M;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/integer_to_roman_numeral.sv @@
// Integer to Roman numeral converter.
// Input channel: value (14 bits) with in_valid / in_stall. A transaction
// takes place at a rising edge with in_valid high and in_stall low.
// Output channel: letter (ASCII), last and empty_res with out_valid /
// out_stall; one transaction per numeral letter, last marks the final one.
// A value with no letters (zero, or a thousands digit of four or more with
// zero lower digits) gives a single transaction with letter 0, last and
// empty_res set.
// One shared subtract-and-compare unit splits the value into digits by
// repeated subtraction of 1000, 100 and 10. Letters then leave one per
// cycle while the receiver does not stall; each letterless place ahead of
// the last lettered one takes a sequencer step of its own.
// in_stall is high from the accepting edge until the last letter is loaded
// into the output register, so the next value is taken while that letter
// still waits. When the receiver stalls, the output register holds its
// transaction and the letter sequencer waits.
// Reset (rst, synchronous) returns to idle and drops out_valid.
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  letter,
  output logic        last,
  output logic        empty_res
);

  `include "integer_to_roman_numeral_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]  state;
  logic [13:0] rem;
  logic [4:0]  thou;
  logic [3:0]  hund;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [1:0]  place;
  logic [1:0]  pos;

  logic [14:0] diff;
  logic        ge;
  logic [2:0]  len_thou, len_hund, len_tens, len_ones, cur_len;
  logic [3:0]  cur_digit;
  logic        rest_zero, all_zero, out_free, pos_end, out_load;
  logic [7:0]  cur_letter;

  // Shared subtractor: remainder minus the weight of the current place.
  assign diff = {1'b0, rem} - {5'd0, i2r_pkg::place_weight(place)};
  assign ge   = ~diff[14];

  // Letter counts per place; thousands of four or more yield none.
  assign len_thou = (thou >= 5'd1 && thou <= 5'd3) ? thou[2:0] : 3'd0;
  assign len_hund = i2r_pkg::digit_len(hund);
  assign len_tens = i2r_pkg::digit_len(tens);
  assign len_ones = i2r_pkg::digit_len(ones);
  assign all_zero = (len_thou == 3'd0) && (len_hund == 3'd0) &&
                    (len_tens == 3'd0) && (len_ones == 3'd0);

  // Select the digit under the sequencer and check lower places for letters.
  always_comb begin
    case (place)
      i2r_pkg::PLACE_THOU: begin
        cur_len   = len_thou;
        cur_digit = 4'd0;
        rest_zero = (len_hund == 3'd0) && (len_tens == 3'd0) && (len_ones == 3'd0);
      end
      i2r_pkg::PLACE_HUND: begin
        cur_len   = len_hund;
        cur_digit = hund;
        rest_zero = (len_tens == 3'd0) && (len_ones == 3'd0);
      end
      i2r_pkg::PLACE_TENS: begin
        cur_len   = len_tens;
        cur_digit = tens;
        rest_zero = (len_ones == 3'd0);
      end
      default: begin
        cur_len   = len_ones;
        cur_digit = ones;
        rest_zero = 1'b1;
      end
    endcase
  end

  assign cur_letter = (place == i2r_pkg::PLACE_THOU) ? i2r_pkg::ASCII_M :
                      i2r_pkg::roman_letter(place, i2r_pkg::digit_sel(cur_digit, pos));
  assign pos_end    = ({1'b0, pos} == (cur_len - 3'd1));
  assign out_free   = ~out_valid | ~out_stall;
  assign in_stall   = (state != ST_IDLE);

  // A transaction is loaded into the output register this cycle.
  assign out_load   = (state == ST_EMIT) && out_free && (all_zero || cur_len != 3'd0);

  // Sequencer: digit split by repeated subtraction, then letter emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rem   <= value;
            thou  <= 5'd0;
            hund  <= 4'd0;
            tens  <= 4'd0;
            place <= i2r_pkg::PLACE_THOU;
            pos   <= 2'd0;
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (ge) begin
            rem <= diff[13:0];
            case (place)
              i2r_pkg::PLACE_THOU: thou <= thou + 5'd1;
              i2r_pkg::PLACE_HUND: hund <= hund + 4'd1;
              default:             tens <= tens + 4'd1;
            endcase
          end else if (place == i2r_pkg::PLACE_TENS) begin
            ones  <= rem[3:0];
            place <= i2r_pkg::PLACE_THOU;
            state <= ST_EMIT;
          end else begin
            place <= place - 2'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (all_zero) begin
              letter    <= i2r_pkg::ASCII_NONE;
              last      <= 1'b1;
              empty_res <= 1'b1;
              state     <= ST_IDLE;
            end else if (cur_len == 3'd0) begin
              place <= place - 2'd1;
            end else begin
              letter    <= cur_letter;
              last      <= pos_end && rest_zero;
              empty_res <= 1'b0;
              if (pos_end) begin
                pos <= 2'd0;
                if (rest_zero) begin
                  state <= ST_IDLE;
                end else begin
                  place <= place - 2'd1;
                end
              end else begin
                pos <= pos + 2'd1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An empty result is always a lone final transaction with no letter.
  `I2R_ASSERT_NOW(a_empty_is_last, out_valid && empty_res, last && letter == i2r_pkg::ASCII_NONE)
  // Accepting a value starts work that blocks the input on the next cycle.
  `I2R_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  // The letter position never runs past the digit's letter count.
  `I2R_ASSERT_NOW(a_pos_in_range, state == ST_EMIT && cur_len != 3'd0,
                  {1'b0, pos} < cur_len)
  // Lower digits stay decimal throughout the split and emission.
  `I2R_ASSERT_NOW(a_digits_decimal, state != ST_IDLE, hund <= 4'd9 && tens <= 4'd9)

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// One letter of a numeral as it leaves the converter.
typedef struct packed {
  logic [7:0] letter;
  logic       last;
  logic       empty_res;
} numeral_char_t;

// Predicts the numeral letters of every accepted value and checks each letter
// transaction against the oldest one still waiting.
class numeral_checker;
  numeral_char_t pending_letters[$];
  int unsigned   errors;

  function new();
    errors = 0;
  endfunction

  // Appends the letters of one decimal digit, given its place's letter triple.
  static function void spell_digit(ref logic [7:0] word[$], input int unsigned digit,
                                   input logic [7:0] lo, input logic [7:0] mi,
                                   input logic [7:0] hi);
    if (digit >= 1 && digit <= 3) begin
      repeat (digit) word.push_back(lo);
    end else if (digit == 4) begin
      word.push_back(lo);
      word.push_back(mi);
    end else if (digit >= 5 && digit <= 8) begin
      word.push_back(mi);
      repeat (digit - 5) word.push_back(lo);
    end else if (digit == 9) begin
      word.push_back(lo);
      word.push_back(hi);
    end
  endfunction

  // Works out the numeral of an accepted value and queues its letters.
  function void accept_value(input logic [13:0] value);
    logic [7:0]    word[$];
    int unsigned   v;
    int unsigned   thou;
    numeral_char_t ch;
    v    = value;
    thou = v / 1000;
    // Thousands above three yield no letters at all.
    if (thou >= 1 && thou <= 3) begin
      repeat (thou) word.push_back(i2r_pkg::ASCII_M);
    end
    spell_digit(word, (v % 1000) / 100, i2r_pkg::ASCII_C, i2r_pkg::ASCII_D,
                i2r_pkg::ASCII_M);
    spell_digit(word, (v % 100) / 10, i2r_pkg::ASCII_X, i2r_pkg::ASCII_L,
                i2r_pkg::ASCII_C);
    spell_digit(word, v % 10, i2r_pkg::ASCII_I, i2r_pkg::ASCII_V, i2r_pkg::ASCII_X);
    // A numeral without letters leaves as one empty transaction.
    if (word.size() == 0) begin
      ch.letter    = i2r_pkg::ASCII_NONE;
      ch.last      = 1'b1;
      ch.empty_res = 1'b1;
      pending_letters.push_back(ch);
    end else begin
      foreach (word[k]) begin
        ch.letter    = word[k];
        ch.last      = (k == word.size() - 1);
        ch.empty_res = 1'b0;
        pending_letters.push_back(ch);
      end
    end
  endfunction

  // Compares one output transaction with the oldest expected letter.
  function void check_letter(input logic [7:0] letter, input logic last,
                             input logic empty_res);
    numeral_char_t want;
    if (pending_letters.size() == 0) begin
      $display("%0t: unexpected letter transaction, expected none, actual %h/%b/%b",
               $time, letter, last, empty_res);
      errors++;
      return;
    end
    want = pending_letters.pop_front();
    if (letter !== want.letter) begin
      $display("%0t: letter mismatch, expected %h actual %h", $time, want.letter, letter);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last);
      errors++;
    end
    if (empty_res !== want.empty_res) begin
      $display("%0t: empty_res mismatch, expected %b actual %b", $time, want.empty_res,
               empty_res);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned RANDOM_VALUES = 320;
  localparam int unsigned CALM_FROM     = 260;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [13:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  letter;
  logic        last;
  logic        empty_res;

  numeral_checker numerals = new();
  bit             gaps_on = 1'b1;
  int unsigned    quiet_cycles = 0;

  // Extremes of the range, every digit form, and the numerals without letters.
  int unsigned corner_values [25] = '{
    0, 1, 4, 5, 9, 40, 90, 400, 900, 1000, 1997, 2763, 3000, 3888, 3999,
    4000, 4444, 5000, 6172, 8888, 9006, 9999, 10000, 16000, 16383
  };

  integer_to_roman_numeral u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .letter    (letter),
    .last      (last),
    .empty_res (empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one value, with an optional idle gap first, and holds it until taken.
  task automatic send_value(input logic [13:0] v);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do begin
      @(posedge clk);
    end while (in_stall);
    numerals.accept_value(v);
    @(negedge clk);
  endtask

  // Draws a value: mostly in range, some above it, some with zero digits.
  function automatic logic [13:0] pick_value();
    int unsigned r;
    case ($urandom_range(0, 9))
      6: r = $urandom_range(10000, 16383);
      7: r = ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 1000
           + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 100
           + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) * 10
           + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
      8: r = $urandom_range(0, 3999);
      9: r = $urandom_range(0, 16) * 1000 + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
      default: r = $urandom_range(0, 9999);
    endcase
    return 14'(r);
  endfunction

  // Receiver stalls in random bursts while idling is enabled.
  always begin
    @(negedge clk);
    if (gaps_on && !rst && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  // Checks output transactions and watches for a stuck pipeline.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      numerals.check_letter(letter, last, empty_res);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset, directed corners, random values, then drain and report.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    out_stall = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_values[i]) begin
      send_value(14'(corner_values[i]));
    end
    for (int unsigned n = 0; n < RANDOM_VALUES; n++) begin
      if (n == CALM_FROM) begin
        gaps_on = 1'b0;
      end
      send_value(pick_value());
    end
    in_valid <= 1'b0;

    while (numerals.pending_letters.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (numerals.errors == 0 && numerals.pending_letters.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/i2r_pkg.sv
rtl/core/integer_to_roman_numeral.sv
verif/testbench.sv
